### src/mtf_pkg.sv
package mtf_pkg;

  localparam int unsigned SYM_W = 8;
  localparam int unsigned POS_W = 8;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last_in_block;
  } mtf_in_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             block_end;
  } mtf_out_t;

  // transaction traveling down the cell chain
  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic [SYM_W-1:0] carry;
    logic [POS_W-1:0] position;
    logic             active;
    logic             found;
    logic             last;
  } mtf_token_t;

endpackage

### src/mtf_cell.sv
module mtf_cell #(
  parameter int unsigned INDEX = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  logic                tok_in_valid,
  input  mtf_pkg::mtf_token_t tok_in,
  output logic                tok_out_valid,
  output mtf_pkg::mtf_token_t tok_out
);

  localparam logic [mtf_pkg::SYM_W-1:0] INIT_SYM = mtf_pkg::SYM_W'(INDEX);
  localparam logic [mtf_pkg::POS_W-1:0] INIT_POS = mtf_pkg::POS_W'(INDEX);

  logic [mtf_pkg::SYM_W-1:0] entry_r, entry_nxt;
  logic                      valid_r;
  mtf_pkg::mtf_token_t       tok_r, tok_nxt;
  logic                      search;
  logic                      hit;

  assign search = tok_in.active && !tok_in.found;
  assign hit    = search && (entry_r == tok_in.symbol);

  // while the token still searches, the carried symbol lands here; on a miss the old entry moves on
  always_comb begin
    entry_nxt = entry_r;
    tok_nxt   = tok_in;
    if (search) begin
      entry_nxt = tok_in.carry;
      if (hit) begin
        tok_nxt.found    = 1'b1;
        tok_nxt.position = INIT_POS;
      end else begin
        tok_nxt.carry = entry_r;
      end
    end
    if (tok_in.last) begin
      entry_nxt = INIT_SYM;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= INIT_SYM;
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= tok_in_valid;
      if (tok_in_valid) begin
        entry_r <= entry_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out_valid = valid_r;
  assign tok_out       = tok_r;

endmodule

### src/move_to_front_encoder.sv
// Accepts one transaction per cycle while the chain is not stalled; each transaction
// walks the cell chain one cell per cycle, so several are in flight at once.
// The whole chain stalls only when a result waiting at the output is not taken
// and the last cell also holds a valid transaction.
// Reset (synchronous, active low) empties the chain and loads the identity order.
module move_to_front_encoder #(
  parameter int unsigned ALPHABET_SIZE = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  mtf_pkg::mtf_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output mtf_pkg::mtf_out_t out_data
);

  logic                chain_valid [ALPHABET_SIZE+1];
  mtf_pkg::mtf_token_t chain_tok   [ALPHABET_SIZE+1];

  logic              take;
  logic              advance;
  logic              out_valid_r;
  mtf_pkg::mtf_out_t out_data_r;

  assign take    = out_ready || !out_valid_r;
  assign advance = take || !chain_valid[ALPHABET_SIZE];

  assign chain_valid[0]           = in_valid;
  assign chain_tok[0].symbol      = in_data.symbol;
  assign chain_tok[0].carry       = in_data.symbol;
  assign chain_tok[0].position    = '0;
  assign chain_tok[0].active      = ({1'b0, in_data.symbol} < (mtf_pkg::SYM_W + 1)'(ALPHABET_SIZE));
  assign chain_tok[0].found       = 1'b0;
  assign chain_tok[0].last        = in_data.last_in_block;

  for (genvar k = 0; k < ALPHABET_SIZE; k++) begin : g_cell
    mtf_cell #(
      .INDEX(k)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .advance      (advance),
      .tok_in_valid (chain_valid[k]),
      .tok_in       (chain_tok[k]),
      .tok_out_valid(chain_valid[k+1]),
      .tok_out      (chain_tok[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= chain_valid[ALPHABET_SIZE];
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r.position  <= chain_tok[ALPHABET_SIZE].position;
      out_data_r.block_end <= chain_tok[ALPHABET_SIZE].last;
    end
  end

  assign in_ready  = advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### dv/mtf_checker.sv
module mtf_checker #(
  parameter int unsigned ALPHABET_SIZE = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  mtf_pkg::mtf_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  mtf_pkg::mtf_out_t out_data,
  output int                fail_count,
  output int                pending
);

  logic [mtf_pkg::SYM_W-1:0] sym_order [ALPHABET_SIZE];
  mtf_pkg::mtf_out_t         coded_q[$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic mtf_pkg::mtf_out_t code_symbol(mtf_pkg::mtf_in_t item);
    mtf_pkg::mtf_out_t res;
    int hit;
    hit = -1;
    for (int k = 0; k < ALPHABET_SIZE; k++) begin
      if (hit < 0 && sym_order[k] == item.symbol) hit = k;
    end
    if (hit > 0) begin
      for (int k = hit; k > 0; k--) sym_order[k] = sym_order[k-1];
      sym_order[0] = item.symbol;
    end
    // symbol outside the alphabet codes as position 0
    res.position  = (hit < 0) ? '0 : mtf_pkg::POS_W'(hit);
    res.block_end = item.last_in_block;
    if (item.last_in_block) begin
      for (int k = 0; k < ALPHABET_SIZE; k++) sym_order[k] = mtf_pkg::SYM_W'(k);
    end
    return res;
  endfunction

  always @(posedge clk) begin
    mtf_pkg::mtf_out_t want;
    if (!rst_n) begin
      for (int k = 0; k < ALPHABET_SIZE; k++) sym_order[k] = mtf_pkg::SYM_W'(k);
      coded_q.delete();
    end else begin
      if (in_valid && in_ready) coded_q.push_back(code_symbol(in_data));
      if (out_valid && out_ready) begin
        if (coded_q.size() == 0) begin
          $error("result with no transaction pending: position %0d block_end %0b",
                 out_data.position, out_data.block_end);
          fail_count++;
        end else begin
          want = coded_q.pop_front();
          if (out_data.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, out_data.position);
            fail_count++;
          end
          if (out_data.block_end !== want.block_end) begin
            $error("block_end: expected %0b, got %0b", want.block_end, out_data.block_end);
            fail_count++;
          end
        end
      end
    end
    pending = coded_q.size();
  end

endmodule

### dv/tb_move_to_front_encoder.sv
module tb_move_to_front_encoder;

  localparam int unsigned ALPHABET = 256;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  mtf_pkg::mtf_in_t  in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  mtf_pkg::mtf_out_t out_data;
  int                fail_count;
  int                pending;

  int idle_pct = 0;
  int stall_pct = 0;

  always #6 clk = ~clk;

  move_to_front_encoder #(.ALPHABET_SIZE(ALPHABET)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  mtf_checker #(.ALPHABET_SIZE(ALPHABET)) chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always @(posedge clk) begin
    out_ready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);
  end

  task automatic send(input logic [7:0] sym, input logic last);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{symbol: sym, last_in_block: last};
    do @(posedge clk); while (!in_ready);
  endtask

  // blocks of random length ending in last_in_block, with reuse of recent
  // symbols so that small positions and deep lists both occur
  task automatic run_phase(input int n_items, input int snd, input int rcv);
    int sent;
    int len;
    int r;
    int n_recent;
    logic [7:0] sym;
    logic [7:0] recent [8];
    idle_pct  = snd;
    stall_pct = rcv;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(15) == 0) ? int'($urandom_range(300, 60))
                                      : int'($urandom_range(40, 1));
      n_recent = 0;
      for (int k = 0; k < len && sent < n_items; k++) begin
        r = int'($urandom_range(99));
        if (r < 45 && n_recent > 0)
          sym = recent[$urandom_range((n_recent < 8 ? n_recent : 8) - 1)];
        else if (r < 52)
          sym = $urandom_range(1) ? 8'hff : 8'h00;
        else
          sym = 8'($urandom_range(255));
        recent[n_recent % 8] = sym;
        n_recent++;
        send(sym, (k == len - 1) || ($urandom_range(49) == 0));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // front hit, deepest hit, repeat, end of block and fresh order after it
    send(8'd0,   1'b0);
    send(8'd255, 1'b0);
    send(8'd255, 1'b0);
    send(8'd0,   1'b0);
    send(8'd128, 1'b0);
    send(8'd1,   1'b0);
    send(8'd254, 1'b1);
    send(8'd255, 1'b0);
    send(8'd255, 1'b1);
    send(8'd0,   1'b1);
    send(8'd7,   1'b0);
    send(8'd7,   1'b1);
    send(8'd170, 1'b0);
    send(8'd85,  1'b1);

    run_phase(260, 0, 0);
    run_phase(260, 64, 0);
    run_phase(260, 0, 64);
    run_phase(260, 25, 25);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (ALPHABET + 40) @(posedge clk);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
